// File: rtl/core/nlcc_pkg.sv
// shared types, character codes and helpers for the nmea line checksum checker
`timescale 1ns / 1ps

package nlcc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned LimitW = 7;

  localparam logic [ByteW-1:0] CharDollar  = 8'h24;
  localparam logic [ByteW-1:0] CharStar    = 8'h2A;
  localparam logic [ByteW-1:0] CharNewline = 8'h0A;
  localparam logic [ByteW-1:0] CharNul     = 8'h00;
  localparam logic [ByteW-1:0] CharZero    = 8'h30;
  localparam logic [ByteW-1:0] CharAlpha   = 8'h37; // 'A' minus ten

  localparam logic [LimitW-1:0] ScanLimitReset = 7'd75;

  typedef enum logic [2:0] {
    PH_DOLLAR = 3'd0,
    PH_BODY   = 3'd1,
    PH_HEX1   = 3'd2,
    PH_HEX2   = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  typedef struct packed {
    logic             sentence_valid;
    logic [ByteW-1:0] computed_checksum;
  } result_t;

  // uppercase ascii hex digit of a nibble
  function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] n);
    logic [ByteW-1:0] n_w;
    n_w = {4'b0000, n};
    if (n < 4'd10) begin
      hex_digit = CharZero + n_w;
    end else begin
      hex_digit = CharAlpha + n_w;
    end
  endfunction

endpackage

// File: rtl/core/nlcc_scanner.sv
// line state tracker: phase machine, running xor, hex capture and verdict
`timescale 1ns / 1ps

module nlcc_scanner #(
  parameter int unsigned LineBufferBytes = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic [nlcc_pkg::ByteW-1:0]       byte_i,
  input  logic [nlcc_pkg::LimitW-1:0]      scan_limit_i,
  output logic                             line_end_o,
  output nlcc_pkg::result_t                result_o
);

  localparam logic [nlcc_pkg::CountW-1:0] BufBytes = nlcc_pkg::CountW'(LineBufferBytes);

  nlcc_pkg::phase_e               phase_q, phase_d;
  logic [nlcc_pkg::CountW-1:0]    count_q, count_d;
  logic [nlcc_pkg::ByteW-1:0]     xor_q, xor_d;
  logic [nlcc_pkg::ByteW-1:0]     hex1_q, hex1_d;
  logic [nlcc_pkg::ByteW-1:0]     hex2_q, hex2_d;
  logic                           bad_q, bad_d;
  logic                           past_limit;

  assign line_end_o = (byte_i == nlcc_pkg::CharNewline) || (count_q >= BufBytes);
  assign past_limit = count_q >= {1'b0, scan_limit_i};

  // next state
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    xor_d   = xor_q;
    hex1_d  = hex1_q;
    hex2_d  = hex2_q;
    bad_d   = bad_q;
    if (step_i) begin
      if (line_end_o) begin
        phase_d = nlcc_pkg::PH_DOLLAR;
        count_d = '0;
        xor_d   = '0;
        hex1_d  = '0;
        hex2_d  = '0;
        bad_d   = 1'b0;
      end else begin
        count_d = count_q + 1'b1;
        if (!bad_q) begin
          unique case (phase_q)
            nlcc_pkg::PH_DOLLAR: begin
              if (byte_i == nlcc_pkg::CharDollar) begin
                phase_d = nlcc_pkg::PH_BODY;
              end else begin
                bad_d = 1'b1;
              end
            end
            nlcc_pkg::PH_BODY: begin
              if (past_limit || byte_i == nlcc_pkg::CharNul) begin
                bad_d = 1'b1;
              end else if (byte_i == nlcc_pkg::CharStar) begin
                phase_d = nlcc_pkg::PH_HEX1;
              end else begin
                xor_d = xor_q ^ byte_i;
              end
            end
            nlcc_pkg::PH_HEX1: begin
              hex1_d  = byte_i;
              phase_d = nlcc_pkg::PH_HEX2;
            end
            nlcc_pkg::PH_HEX2: begin
              hex2_d  = byte_i;
              phase_d = nlcc_pkg::PH_DONE;
            end
            nlcc_pkg::PH_DONE: begin
              phase_d = phase_q;
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
    end
  end

  // verdict for the line held so far
  always_comb begin
    result_o.computed_checksum = xor_q;
    result_o.sentence_valid    = !bad_q
                                 && (phase_q == nlcc_pkg::PH_HEX1
                                     || phase_q == nlcc_pkg::PH_HEX2
                                     || phase_q == nlcc_pkg::PH_DONE)
                                 && (hex1_q == nlcc_pkg::hex_digit(xor_q[7:4]))
                                 && (hex2_q == nlcc_pkg::hex_digit(xor_q[3:0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nlcc_pkg::PH_DOLLAR;
      count_q <= '0;
      xor_q   <= '0;
      hex1_q  <= '0;
      hex2_q  <= '0;
      bad_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      xor_q   <= xor_d;
      hex1_q  <= hex1_d;
      hex2_q  <= hex2_d;
      bad_q   <= bad_d;
    end
  end

endmodule

// File: rtl/core/nmea_line_checksum_check_unit.sv
// top level of the nmea line checksum checker: scan limit register, input register, scanner, result register
`timescale 1ns / 1ps
// a line-ending beat's result passes through the input register and then the
//   result register, from which it is offered on the result channel
// throughput: one byte beat per cycle; only a held result with out_ready_i low
//   stalls a line-ending byte in the input register, and hence the input
// reset: line state cleared (expecting dollar), scan_limit back to 75, no
//   beats held on either side

module nmea_line_checksum_check_unit #(
  parameter int unsigned LineBufferBytes = 128  // 8 to 255
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // byte input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [nlcc_pkg::ByteW-1:0]  rx_byte_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        sentence_valid_o,
  output logic [nlcc_pkg::ByteW-1:0]  computed_checksum_o,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [nlcc_pkg::LimitW-1:0] cfg_wdata_i
);

  // scan limit register
  logic [nlcc_pkg::LimitW-1:0] scan_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_limit_q <= nlcc_pkg::ScanLimitReset;
    end else if (cfg_we_i) begin
      scan_limit_q <= cfg_wdata_i;
    end
  end

  // input register: one byte beat waiting to be scanned
  logic                       in_full_q, in_full_d;
  logic [nlcc_pkg::ByteW-1:0] in_byte_q;
  logic                       line_end;
  logic                       consume;
  logic                       in_take;
  nlcc_pkg::result_t          scan_res;

  // result register
  logic                       out_full_q, out_full_d;
  nlcc_pkg::result_t          out_res_q;

  // a byte leaves the input register unless it closes a line and the
  // result register cannot take the verdict this cycle
  assign consume    = in_full_q && (!line_end || !out_full_q || out_ready_i);
  assign in_ready_o = !in_full_q || consume;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_full_d = in_full_q;
    if (in_take) begin
      in_full_d = 1'b1;
    end else if (consume) begin
      in_full_d = 1'b0;
    end
  end

  always_comb begin
    out_full_d = out_full_q;
    if (consume && line_end) begin
      out_full_d = 1'b1;
    end else if (out_ready_i) begin
      out_full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q  <= 1'b0;
      out_full_q <= 1'b0;
    end else begin
      in_full_q  <= in_full_d;
      out_full_q <= out_full_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
    if (consume && line_end) begin
      out_res_q <= scan_res;
    end
  end

  // line state and verdict logic
  nlcc_scanner #(
    .LineBufferBytes (LineBufferBytes)
  ) u_scanner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (consume),
    .byte_i       (in_byte_q),
    .scan_limit_i (scan_limit_q),
    .line_end_o   (line_end),
    .result_o     (scan_res)
  );

  assign out_valid_o         = out_full_q;
  assign sentence_valid_o    = out_res_q.sentence_valid;
  assign computed_checksum_o = out_res_q.computed_checksum;

endmodule
